FILE: design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/jets_pkg.sv
// Types and constants of the Julia escape-time shader.
package jets_pkg;

	localparam int IN_W       = 31;
	localparam int C_W        = 32;
	localparam int MAXIT_W    = 16;
	localparam int ESC_W      = 17;
	localparam int SHADE_W    = 8;
	localparam int S_DATA_W   = 64;
	localparam int M_DATA_W   = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int QUOT_W     = 9;
	localparam int DIV_STEP_W = $clog2(QUOT_W);

	localparam logic [QUOT_W-1:0] SHADE_MAX = 9'd255;

	localparam logic signed [C_W-1:0]   C_REAL_RST   = -32'sd214748365;
	localparam logic signed [C_W-1:0]   C_IMAG_RST   = 32'sd41875931;
	localparam logic [MAXIT_W-1:0]      MAX_ITER_RST = 16'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_C_REAL   = 2'd0,
		REG_C_IMAG   = 2'd1,
		REG_MAX_ITER = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_UPD,
		ST_DIV_INIT,
		ST_DIV_RUN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic upd;
		logic div_start;
		logic div_step;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic iter_done;
		logic div_last;
		logic out_free;
	} dp_status_t;

endpackage

FILE: design/jets_ctrl.sv
// Controller state machine sequencing iterations, shade division and result output.
module jets_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_valid,
	output logic                 s_ready,
	input  jets_pkg::dp_status_t status,
	output jets_pkg::dp_cmd_t    cmd
);

	jets_pkg::state_t state_q;
	jets_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jets_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		s_ready = 1'b0;
		case (state_q)
			jets_pkg::ST_IDLE: begin
				s_ready = 1'b1;
				if (s_valid) begin
					cmd.load = 1'b1;
					state_d  = jets_pkg::ST_MUL;
				end
			end
			jets_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = jets_pkg::ST_UPD;
			end
			jets_pkg::ST_UPD: begin
				cmd.upd = 1'b1;
				if (status.iter_done) begin
					state_d = jets_pkg::ST_DIV_INIT;
				end else begin
					state_d = jets_pkg::ST_MUL;
				end
			end
			jets_pkg::ST_DIV_INIT: begin
				cmd.div_start = 1'b1;
				state_d       = jets_pkg::ST_DIV_RUN;
			end
			jets_pkg::ST_DIV_RUN: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = jets_pkg::ST_FIN;
				end
			end
			jets_pkg::ST_FIN: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = jets_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = jets_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: design/jets_div.sv
// Restoring divider forming the grey shade from the escape count and the limit.
module jets_div #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          step,
	input  logic [COUNT_WIDTH:0]          count,
	input  logic [COUNT_WIDTH-1:0]        limit,
	output logic                          last,
	output logic [jets_pkg::SHADE_W-1:0]  shade
);

	localparam int NW = COUNT_WIDTH + 9;
	localparam int QW = jets_pkg::QUOT_W;
	localparam int SW = jets_pkg::DIV_STEP_W;
	localparam int HW = jets_pkg::SHADE_W;

	logic [NW-1:0] num;
	logic [NW-1:0] dvs;
	logic [NW-1:0] rem_q;
	logic [QW-1:0] quot_q;
	logic [SW-1:0] step_q;

	// The numerator is 255 * count + limit - 1, the ceiling form of the quotient.
	assign num = (NW'(count) << 8) - NW'(count) + NW'(limit) - NW'(1);
	assign dvs = NW'(limit) << step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (start) begin
			step_q <= SW'(QW - 1);
		end else if (step) begin
			step_q <= step_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			quot_q <= '0;
		end else if (step) begin
			if (rem_q >= dvs) begin
				rem_q  <= rem_q - dvs;
				quot_q <= {quot_q[QW-2:0], 1'b1};
			end else begin
				quot_q <= {quot_q[QW-2:0], 1'b0};
			end
		end
	end

	assign last  = (step_q == '0);
	assign shade = ((limit == '0) || (quot_q >= jets_pkg::SHADE_MAX)) ? '0
		: HW'(jets_pkg::SHADE_MAX - quot_q);

endmodule

FILE: design/jets_datapath.sv
// Datapath: iterate registers, squaring products, escape test, shade divider and output register.
module jets_datapath #(
	parameter int FRAC_BITS   = 28,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  jets_pkg::dp_cmd_t                  cmd,
	output jets_pkg::dp_status_t               status,
	input  logic signed [jets_pkg::IN_W-1:0]   start_real,
	input  logic signed [jets_pkg::IN_W-1:0]   start_imag,
	input  logic signed [jets_pkg::C_W-1:0]    c_real,
	input  logic signed [jets_pkg::C_W-1:0]    c_imag,
	input  logic [COUNT_WIDTH-1:0]             limit,
	input  logic                               m_ready,
	output logic                               m_valid,
	output logic [jets_pkg::ESC_W-1:0]         escape_count,
	output logic [jets_pkg::SHADE_W-1:0]       grey_shade
);

	localparam int ZW    = ((FRAC_BITS + 4 > jets_pkg::C_W) ? FRAC_BITS + 4 : jets_pkg::C_W) + 2;
	localparam int MW    = FRAC_BITS + 2;
	localparam int PW    = 2 * MW;
	localparam int SQW   = PW - FRAC_BITS;
	localparam int CNT_W = COUNT_WIDTH + 1;
	localparam int ESCW  = jets_pkg::ESC_W;

	localparam logic [ZW-1:0]  TWO  = ZW'(2) << FRAC_BITS;
	localparam logic [SQW:0]   FOUR = (SQW + 1)'(4) << FRAC_BITS;

	logic signed [ZW-1:0]       zr_q;
	logic signed [ZW-1:0]       zi_q;
	logic [COUNT_WIDTH-1:0]     n_q;
	logic [PW-1:0]              prr_q;
	logic [PW-1:0]              pii_q;
	logic [PW-1:0]              pri_q;
	logic                       stop_q;
	logic                       neg_q;
	logic                       m_valid_q;
	logic [ESCW-1:0]            esc_q;
	logic [jets_pkg::SHADE_W-1:0] shade_q;

	logic [ZW-1:0]              ar;
	logic [ZW-1:0]              ai;
	logic [SQW-1:0]             zr2;
	logic [SQW-1:0]             zi2;
	logic [SQW:0]               sq_sum;
	logic [SQW:0]               cross_term;
	logic [ZW-1:0]              cross_z;
	logic [ZW-1:0]              zr_next;
	logic [ZW-1:0]              zi_next;
	logic                       done;
	logic [CNT_W-1:0]           count;
	logic                       div_last;
	logic [jets_pkg::SHADE_W-1:0] shade;

	assign ar = zr_q[ZW-1] ? ZW'(-zr_q) : ZW'(zr_q);
	assign ai = zi_q[ZW-1] ? ZW'(-zi_q) : ZW'(zi_q);

	assign zr2        = prr_q[PW-1:FRAC_BITS];
	assign zi2        = pii_q[PW-1:FRAC_BITS];
	assign sq_sum     = (SQW + 1)'(zr2) + (SQW + 1)'(zi2);
	assign cross_term = pri_q[PW-1:FRAC_BITS-1];
	assign cross_z    = ZW'(cross_term);
	assign zr_next    = ZW'(zr2) - ZW'(zi2) + ZW'(c_real);
	assign zi_next    = (neg_q ? (-cross_z) : cross_z) + ZW'(c_imag);
	assign done       = stop_q | (sq_sum > FOUR);

	assign count = CNT_W'(n_q) + CNT_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			zr_q <= ZW'(start_real);
			zi_q <= ZW'(start_imag);
			n_q  <= '0;
		end else if (cmd.upd && !done) begin
			zr_q <= zr_next;
			zi_q <= zi_next;
			n_q  <= n_q + 1'b1;
		end
	end

	// Magnitudes are only used when neither exceeds two, so MW bits hold them.
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prr_q  <= PW'(ar[MW-1:0]) * PW'(ar[MW-1:0]);
			pii_q  <= PW'(ai[MW-1:0]) * PW'(ai[MW-1:0]);
			pri_q  <= PW'(ar[MW-1:0]) * PW'(ai[MW-1:0]);
			stop_q <= (ar > TWO) | (ai > TWO) | (n_q >= limit);
			neg_q  <= zr_q[ZW-1] ^ zi_q[ZW-1];
		end
	end

	jets_div #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.step  (cmd.div_step),
		.count (count),
		.limit (limit),
		.last  (div_last),
		.shade (shade)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_ready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			esc_q   <= ESCW'(count);
			shade_q <= shade;
		end
	end

	assign status.iter_done = done;
	assign status.div_last  = div_last;
	assign status.out_free  = !m_valid_q || m_ready;

	assign m_valid      = m_valid_q;
	assign escape_count = esc_q;
	assign grey_shade   = shade_q;

endmodule

FILE: design/julia_escape_time_shader.sv
// Top level of the Julia escape-time shader: configuration registers, controller and datapath.
//
// Input beats on s_tvalid/s_tready/s_tdata carry one starting point z in signed fixed point.
// Each point is iterated z = z*z + c with the configured c until |z|^2 exceeds four or
// the configured iteration limit is reached. One result beat on m_tvalid/m_tready/m_tdata
// follows every input beat, carrying the escape count and a grey shade.
// Each iteration forms the three squaring products first, then makes the escape test
// and the update of z. The shade then needs a set-up step and a restoring divider that
// forms a nine-bit quotient, after which the output register is loaded.
// Once the result is in the output register, the block returns to idle and takes the
// next input beat, so it works on one point at a time.
// A finished result waits in the output register while the next point is already taken;
// if the receiver still stalls when the following result is ready, that one holds in the
// datapath until the output register empties.
// Configuration writes on cfg_wen/cfg_index/cfg_data take effect at once; the user must
// make them only while no point is in flight, as the block does not enforce this.
// Reset restores the default constant and limit and empties the block.
module julia_escape_time_shader #(
	parameter int FRAC_BITS   = 28,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [jets_pkg::S_DATA_W-1:0]     s_tdata,   // start_real [30:0], start_imag [61:31]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [jets_pkg::M_DATA_W-1:0]     m_tdata,   // escape_count [16:0], grey_shade [24:17]
	input  logic                              cfg_wen,
	input  logic [jets_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [jets_pkg::C_W-1:0]          cfg_data
);

	`include "assert_macros.svh"

	localparam int IW = jets_pkg::IN_W;

	logic signed [jets_pkg::C_W-1:0]   c_real_q;
	logic signed [jets_pkg::C_W-1:0]   c_imag_q;
	logic [jets_pkg::MAXIT_W-1:0]      max_iter_q;
	logic [COUNT_WIDTH-1:0]            limit;

	jets_pkg::dp_cmd_t                 cmd;
	jets_pkg::dp_status_t              status;
	logic [jets_pkg::ESC_W-1:0]        escape_count;
	logic [jets_pkg::SHADE_W-1:0]      grey_shade;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_real_q   <= jets_pkg::C_REAL_RST;
			c_imag_q   <= jets_pkg::C_IMAG_RST;
			max_iter_q <= jets_pkg::MAX_ITER_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				jets_pkg::REG_C_REAL: begin
					c_real_q <= cfg_data;
				end
				jets_pkg::REG_C_IMAG: begin
					c_imag_q <= cfg_data;
				end
				jets_pkg::REG_MAX_ITER: begin
					max_iter_q <= cfg_data[jets_pkg::MAXIT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign limit = COUNT_WIDTH'(max_iter_q);

	jets_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.s_valid(s_tvalid),
		.s_ready(s_tready),
		.status (status),
		.cmd    (cmd)
	);

	jets_datapath #(
		.FRAC_BITS  (FRAC_BITS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.start_real  (s_tdata[IW-1:0]),
		.start_imag  (s_tdata[2*IW-1:IW]),
		.c_real      (c_real_q),
		.c_imag      (c_imag_q),
		.limit       (limit),
		.m_ready     (m_tready),
		.m_valid     (m_tvalid),
		.escape_count(escape_count),
		.grey_shade  (grey_shade)
	);

	assign m_tdata = {{(jets_pkg::M_DATA_W - jets_pkg::ESC_W - jets_pkg::SHADE_W){1'b0}},
		grey_shade, escape_count};

	`ASSERT_NEXT(a_load_then_mul, s_tvalid && s_tready, cmd.mul, "accepted beat not followed by a multiply step")
	`ASSERT_NEXT(a_div_start_then_step, cmd.div_start, cmd.div_step && !s_tready, "divider start not followed by a step")
	`ASSERT_IMPL(a_out_load_free, cmd.out_load, status.out_free, "result loaded into an occupied output register")
	`ASSERT_IMPL(a_cmd_onehot, 1'b1, $onehot0(cmd), "more than one datapath command in a cycle")

endmodule
